@@ design/lckd_pkg.sv @@
package lckd_pkg;

	localparam int unsigned LINE_LIMIT = 17;
	localparam int unsigned CNT_W      = $clog2(LINE_LIMIT + 1);
	localparam int unsigned WIN_DEPTH  = 9;
	localparam int unsigned KW_COUNT   = 5;
	localparam int unsigned KW_MAX     = 10;

	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] CHAR_LF = 8'd10;
	localparam logic [7:0] CHAR_NUL = 8'd0;

	typedef logic [WIN_DEPTH-1:0][7:0] window_t;
	typedef logic [KW_COUNT-1:0] hits_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_R1_ON  = 3'd1,
		CMD_R1_OFF = 3'd2,
		CMD_R2_ON  = 3'd3,
		CMD_R2_OFF = 3'd4,
		CMD_TEMP   = 3'd5
	} cmd_t;

	typedef logic [KW_MAX-1:0][7:0] kw_text_t;

	localparam kw_text_t KW_TEXT [KW_COUNT] = '{
		{8'h00, "relay1 on"},
		{"relay1 off"},
		{8'h00, "relay2 on"},
		{"relay2 off"},
		{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "temp?"}
	};

	localparam int unsigned KW_LEN [KW_COUNT] = '{9, 10, 9, 10, 5};

	// Character i of keyword k, counted from the start of the keyword.
	function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned i);
		kw_char = KW_TEXT[k][KW_LEN[k] - 1 - i];
	endfunction

endpackage

@@ design/lckd_match.sv @@
module lckd_match (
	input  lckd_pkg::window_t win,
	input  logic [7:0]        rx_char,
	output lckd_pkg::hits_t   hits
);
	import lckd_pkg::*;

	// A keyword ends with the new character when its earlier characters sit in
	// the window, newest first.
	always_comb begin
		for (int unsigned k = 0; k < KW_COUNT; k++) begin
			hits[k] = (rx_char == kw_char(k, KW_LEN[k] - 1));
			for (int unsigned j = 0; j < KW_MAX - 1; j++) begin
				if (j + 2 <= KW_LEN[k]) begin
					if (win[j] != kw_char(k, KW_LEN[k] - 2 - j)) begin
						hits[k] = 1'b0;
					end
				end
			end
		end
	end

endmodule

@@ design/line_command_keyword_decoder_unit.sv @@
// Decodes relay and temperature commands from a stream of received bytes, one
// byte per transaction, and gives exactly one result per byte. Up to 17 bytes
// of a line are examined; a zero byte stops keyword matching until the line
// ends, and a carriage return or line feed ends the line, reports the command
// of highest priority that was seen and, for a relay command, switches the
// relay at once. A byte passes through an input register, then a result
// register, and a new byte can be accepted in every cycle while the result
// side is not stalled.
module line_command_keyword_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] command_code,
	output logic       line_end,
	output logic       relay_one,
	output logic       relay_two
);
	import lckd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;

	window_t    win_q;
	count_t     kept_q;
	hits_t      hits_q;
	logic       zero_q;
	logic [1:0] relay_q;

	logic       out_valid_q;
	cmd_t       code_q;
	logic       line_end_q;

	logic       out_free;
	logic       advance;
	logic       is_end;
	logic       keep;
	hits_t      match_hits;
	cmd_t       code_d;
	logic [1:0] relay_d;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	assign is_end = (byte_s1 == CHAR_CR) || (byte_s1 == CHAR_LF);
	assign keep   = !is_end && (kept_q < count_t'(LINE_LIMIT));

	lckd_match u_match (
		.win     (win_q),
		.rx_char (byte_s1),
		.hits    (match_hits)
	);

	always_comb begin
		code_d = CMD_NONE;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (hits_q[k]) begin
				code_d = cmd_t'(3'(k + 1));
			end
		end
		if (!is_end) begin
			code_d = CMD_NONE;
		end
		relay_d = relay_q;
		case (code_d)
			CMD_R1_ON:  relay_d[0] = 1'b1;
			CMD_R1_OFF: relay_d[0] = 1'b0;
			CMD_R2_ON:  relay_d[1] = 1'b1;
			CMD_R2_OFF: relay_d[1] = 1'b0;
			default:    relay_d = relay_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			kept_q  <= '0;
			hits_q  <= '0;
			zero_q  <= 1'b0;
			relay_q <= 2'b00;
		end else if (advance) begin
			relay_q <= relay_d;
			if (is_end) begin
				win_q  <= '0;
				kept_q <= '0;
				hits_q <= '0;
				zero_q <= 1'b0;
			end else if (keep) begin
				if (byte_s1 == CHAR_NUL) begin
					zero_q <= 1'b1;
				end else if (!zero_q) begin
					hits_q <= hits_q | match_hits;
				end
				win_q  <= {win_q[WIN_DEPTH-2:0], byte_s1};
				kept_q <= kept_q + count_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			code_q     <= code_d;
			line_end_q <= is_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign command_code = code_q;
	assign line_end     = line_end_q;
	assign relay_one    = relay_q[0];
	assign relay_two    = relay_q[1];

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= count_t'(LINE_LIMIT))
		else $error("kept byte count passed the line limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_end |=> (hits_q == '0) && (kept_q == '0) && !zero_q)
		else $error("line state not cleared after line end");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_end |-> command_code == CMD_NONE)
		else $error("command reported on a byte that did not end a line");

	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(relay_q) && $stable(hits_q))
		else $error("line state changed without a transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_end |=> $stable(relay_q))
		else $error("relay switched on a byte that did not end a line");
`endif

endmodule

@@ sim/line_command_keyword_decoder_checker.sv @@
`timescale 1ns / 1ps

module line_command_keyword_decoder_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [2:0] command_code,
	input  logic       line_end,
	input  logic       relay_one,
	input  logic       relay_two,
	output int         fail_count,
	output int         pending
);
	import lckd_pkg::*;

	typedef struct packed {
		logic [2:0] code;
		logic       ended;
		logic       r1;
		logic       r2;
	} line_result_t;

	string        keywords [KW_COUNT];
	logic [7:0]   recent [WIN_DEPTH];
	int unsigned  kept;
	logic [KW_COUNT-1:0] hits;
	logic         zero_seen;
	logic [1:0]   relays;
	line_result_t decoded_q [$];

	initial begin
		keywords = '{"relay1 on", "relay1 off", "relay2 on", "relay2 off", "temp?"};
		fail_count = 0;
		pending = 0;
	end

	task automatic clear_line();
		for (int j = 0; j < WIN_DEPTH; j++)
			recent[j] = 8'h00;
		kept = 0;
		hits = '0;
		zero_seen = 1'b0;
	endtask

	function automatic logic keyword_ends_here(input int unsigned k, input logic [7:0] c);
		string w;
		int unsigned n;
		w = keywords[k];
		n = w.len();
		if (w[n-1] != c)
			return 1'b0;
		for (int unsigned j = 0; j + 2 <= n; j++)
			if (recent[j] != w[n-2-j])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic decode_byte(input logic [7:0] c, output line_result_t res);
		cmd_t code;
		logic ended;
		code = CMD_NONE;
		ended = 1'b0;
		if (c == CHAR_CR || c == CHAR_LF) begin
			ended = 1'b1;
			for (int k = KW_COUNT - 1; k >= 0; k--)
				if (hits[k])
					code = cmd_t'(k + 1);
			case (code)
				CMD_R1_ON:  relays[0] = 1'b1;
				CMD_R1_OFF: relays[0] = 1'b0;
				CMD_R2_ON:  relays[1] = 1'b1;
				CMD_R2_OFF: relays[1] = 1'b0;
				default: ;
			endcase
			clear_line();
		end else if (kept < LINE_LIMIT) begin
			if (c == CHAR_NUL) begin
				zero_seen = 1'b1;
			end else if (!zero_seen) begin
				for (int unsigned k = 0; k < KW_COUNT; k++)
					if (keyword_ends_here(k, c))
						hits[k] = 1'b1;
			end
			for (int j = WIN_DEPTH - 1; j > 0; j--)
				recent[j] = recent[j-1];
			recent[0] = c;
			kept++;
		end
		res.code = code;
		res.ended = ended;
		res.r1 = relays[0];
		res.r2 = relays[1];
	endtask

	task automatic report_failure(input string what, input line_result_t exp,
			input line_result_t got);
		fail_count++;
		if (fail_count <= 10)
			$display({"%t %s: expected code %0d end %b r1 %b r2 %b, ",
				"got code %0d end %b r1 %b r2 %b"},
				$realtime, what, exp.code, exp.ended, exp.r1, exp.r2,
				got.code, got.ended, got.r1, got.r2);
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_result_t got;
		line_result_t exp;
		if (!arst_n) begin
			clear_line();
			relays = 2'b00;
			decoded_q.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{command_code, line_end, relay_one, relay_two};
				if (decoded_q.size() == 0) begin
					report_failure("unexpected transaction", '0, got);
				end else begin
					exp = decoded_q.pop_front();
					if (got !== exp)
						report_failure("result mismatch", exp, got);
				end
			end
			if (in_valid && !in_stall) begin
				decode_byte(rx_byte, exp);
				decoded_q.push_back(exp);
			end
			pending = decoded_q.size();
		end
	end

endmodule

@@ sim/line_command_keyword_decoder_unit_tb.sv @@
`timescale 1ns / 1ps

module line_command_keyword_decoder_unit_tb;
	import lckd_pkg::*;

	localparam int unsigned ITEM_TARGET = 1750;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] command_code;
	logic       line_end;
	logic       relay_one;
	logic       relay_two;

	int          fail_count;
	int          pending;
	int unsigned cycle_count;
	int unsigned items_sent;
	int unsigned burst_left;
	string       keywords [KW_COUNT];
	logic [7:0]  line_bytes [$];

	line_command_keyword_decoder_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.command_code (command_code),
		.line_end     (line_end),
		.relay_one    (relay_one),
		.relay_two    (relay_two)
	);

	line_command_keyword_decoder_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.command_code (command_code),
		.line_end     (line_end),
		.relay_one    (relay_one),
		.relay_two    (relay_two),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic put_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		rx_byte <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_line();
		foreach (line_bytes[i]) begin
			items_sent++;
			put_byte(line_bytes[i]);
		end
		line_bytes.delete();
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_bytes.push_back(s[i]);
	endtask

	task automatic push_filler(input int unsigned n);
		repeat (n) line_bytes.push_back(8'($urandom_range(32, 126)));
	endtask

	task automatic build_random_line();
		int unsigned kind;
		string w;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			push_filler($urandom_range(0, 4));
			push_text(keywords[$urandom_range(0, KW_COUNT - 1)]);
			if ($urandom_range(0, 4) == 0)
				push_text(keywords[$urandom_range(0, KW_COUNT - 1)]);
			push_filler($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0)
				line_bytes.insert($urandom_range(0, line_bytes.size() - 1), CHAR_NUL);
		end else if (kind < 75) begin
			w = keywords[$urandom_range(0, KW_COUNT - 1)];
			if ($urandom_range(0, 1))
				w = w.substr(0, $urandom_range(0, w.len() - 2));
			else
				w[$urandom_range(0, w.len() - 1)] = byte'($urandom_range(32, 126));
			push_filler($urandom_range(0, 3));
			push_text(w);
		end else if (kind < 85) begin
			push_filler($urandom_range(LINE_LIMIT - 9, LINE_LIMIT + 6));
			push_text(keywords[$urandom_range(0, KW_COUNT - 1)]);
		end else begin
			repeat ($urandom_range(0, 20)) line_bytes.push_back(8'($urandom_range(0, 255)));
		end
		line_bytes.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
	endtask

	initial begin
		int unsigned seg;
		int unsigned span;
		int unsigned mode;
		int unsigned period;
		seg = 0;
		out_stall <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			seg++;
			if (seg == 6 || seg % 50 == 0) begin
				repeat (150) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end else begin
				span = $urandom_range(10, 60);
				mode = $urandom_range(0, 3);
				period = $urandom_range(2, 5);
				for (int unsigned i = 0; i < span; i++) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 2) == 0);
						2: out_stall <= ($urandom_range(0, 2) != 0);
						default: out_stall <= (i % period == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		in_valid <= 1'b0;
		rx_byte <= 8'h00;
		arst_n <= 1'b0;
		burst_left = 0;
		items_sent = 0;
		keywords = '{"relay1 on", "relay1 off", "relay2 on", "relay2 off", "temp?"};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		line_bytes = '{8'hFF, CHAR_NUL, CHAR_CR};
		send_line();
		line_bytes.push_back(CHAR_LF);
		send_line();
		push_text("temp?");
		line_bytes.push_back(CHAR_CR);
		send_line();
		push_text("relay1 on");
		line_bytes.push_back(CHAR_LF);
		send_line();
		push_text("relay2 on");
		line_bytes.push_back(CHAR_CR);
		send_line();

		while (items_sent < ITEM_TARGET) begin
			build_random_line();
			send_line();
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
